// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL files that carry checks.
// Each macro takes a label, a clock, an active-low reset, a condition,
// a consequence and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rcwa_pkg.sv =====
// ============================================================================
// rcwa_pkg
// Shared types and constants of the ring code weight analyzer.
// ============================================================================
`default_nettype none

package rcwa_pkg;

	// Generator row registers: six 2-bit symbols each.
	localparam int REG_W     = 12;
	localparam int REG_COUNT = 8;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam int SYM_MAX   = REG_W / 2;

	// Configuration port index width; indexes past the last row are ignored.
	localparam int CFG_IDX_W = 4;

	// Item field widths.
	localparam int MSG_W  = 8;
	localparam int CNT_W  = 3;
	localparam int BIN_W  = 9;
	localparam int DUAL_W = 13;

	localparam logic [BIN_W-1:0]  BIN_MAX  = {BIN_W{1'b1}};
	localparam logic [DUAL_W-1:0] DUAL_MAX = {DUAL_W{1'b1}};

	// Item modes.
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DUAL   = 1'b1;

	// Ring symbol codes.
	localparam logic [1:0] SYM_ZERO = 2'b00;
	localparam logic [1:0] SYM_A    = 2'b01;
	localparam logic [1:0] SYM_B    = 2'b10;
	localparam logic [1:0] SYM_C    = 2'b11;

	typedef logic [REG_COUNT-1:0][REG_W-1:0] gen_rows_t;

	// Per-item result of the symbol unit.
	typedef struct packed {
		logic [REG_W-1:0] codeword;
		logic [CNT_W-1:0] weight;
		logic [CNT_W-1:0] a_cnt;
		logic [CNT_W-1:0] b_cnt;
		logic [CNT_W-1:0] c_cnt;
		logic             dual;
	} sym_res_t;

	// Output register contents.
	typedef struct packed {
		logic [REG_W-1:0]  codeword;
		logic [CNT_W-1:0]  weight;
		logic [CNT_W-1:0]  zero_count;
		logic [CNT_W-1:0]  a_count;
		logic [CNT_W-1:0]  b_count;
		logic [CNT_W-1:0]  c_count;
		logic [BIN_W-1:0]  bin_count;
		logic [CNT_W-1:0]  min_weight;
		logic              is_dual;
		logic [DUAL_W-1:0] dual_count;
	} out_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcwa_item_if.sv =====
// ============================================================================
// rcwa_item_if
// Input channel: one word per message or candidate, valid/ready handshake.
// ============================================================================
`default_nettype none

interface rcwa_item_if import rcwa_pkg::*; ();

	logic             valid;
	logic             ready;
	logic             mode;
	logic [MSG_W-1:0] message;
	logic [REG_W-1:0] candidate;
	logic             clear;

	modport source (output valid, output mode, output message, output candidate,
		output clear, input ready);
	modport sink (input valid, input mode, input message, input candidate,
		input clear, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/rcwa_result_if.sv =====
// ============================================================================
// rcwa_result_if
// Output channel: one result word per item, valid/ready handshake.
// ============================================================================
`default_nettype none

interface rcwa_result_if import rcwa_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [REG_W-1:0]  codeword;
	logic [CNT_W-1:0]  weight;
	logic [CNT_W-1:0]  zero_count;
	logic [CNT_W-1:0]  a_count;
	logic [CNT_W-1:0]  b_count;
	logic [CNT_W-1:0]  c_count;
	logic [BIN_W-1:0]  bin_count;
	logic [CNT_W-1:0]  min_weight;
	logic              is_dual;
	logic [DUAL_W-1:0] dual_count;

	modport source (output valid, output codeword, output weight, output zero_count,
		output a_count, output b_count, output c_count, output bin_count,
		output min_weight, output is_dual, output dual_count, input ready);
	modport sink (input valid, input codeword, input weight, input zero_count,
		input a_count, input b_count, input c_count, input bin_count,
		input min_weight, input is_dual, input dual_count, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/rcwa_hist_ram.sv =====
// ============================================================================
// rcwa_hist_ram
// Histogram storage: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module rcwa_hist_ram #(
	parameter int DEPTH = 7,
	parameter int AW    = 3,
	parameter int DW    = 9
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued, so a stalled item keeps it.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rcwa_symbol_unit.sv =====
// ============================================================================
// rcwa_symbol_unit
// Builds the codeword from the selected rows, counts its symbols and runs the
// duality test of a candidate against the rows.
// ============================================================================
`default_nettype none

module rcwa_symbol_unit import rcwa_pkg::*; #(
	parameter int SYMBOLS = 6,
	parameter int ROWS    = 8
) (
	input  wire logic             mode,
	input  wire logic [MSG_W-1:0] message,
	input  wire logic [REG_W-1:0] candidate,
	input  wire gen_rows_t        gen_rows,
	output sym_res_t              res
);

	// Symbols beyond the register width always read as zero.
	localparam int ACT = (SYMBOLS < SYM_MAX) ? SYMBOLS : SYM_MAX;

	logic [REG_W-1:0] cw;
	logic [REG_W-1:0] mask;
	logic [CNT_W-1:0] na, nb, nc;
	logic             hit;
	logic [1:0]       sym;
	logic [1:0]       rsym;

	always_comb begin
		cw   = '0;
		mask = '0;
		na   = '0;
		nb   = '0;
		nc   = '0;
		hit  = 1'b0;
		sym  = SYM_ZERO;
		rsym = SYM_ZERO;
		for (int k = 0; k < ROWS; k++) begin
			if (message[k]) begin
				cw = cw ^ gen_rows[k];
			end
		end
		for (int m = 0; m < ACT; m++) begin
			mask[2*m +: 2] = 2'b11;
		end
		cw = cw & mask;
		for (int m = 0; m < ACT; m++) begin
			sym = cw[2*m +: 2];
			case (sym)
				SYM_A:   na = na + 1'b1;
				SYM_B:   nb = nb + 1'b1;
				SYM_C:   nc = nc + 1'b1;
				default: ;
			endcase
		end
		// A product is nonzero when the candidate symbol is nonzero and the
		// row symbol is a or b.
		for (int k = 0; k < ROWS; k++) begin
			for (int m = 0; m < ACT; m++) begin
				rsym = gen_rows[k][2*m +: 2];
				if ((candidate[2*m +: 2] != SYM_ZERO) && (rsym[0] ^ rsym[1])) begin
					hit = 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (mode == MODE_ENCODE) begin
			res.codeword = cw;
			res.a_cnt    = na;
			res.b_cnt    = nb;
			res.c_cnt    = nc;
			res.weight   = na + nb + nc;
			res.dual     = 1'b0;
		end else begin
			res.codeword = '0;
			res.a_cnt    = '0;
			res.b_cnt    = '0;
			res.c_cnt    = '0;
			res.weight   = '0;
			res.dual     = !hit;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ring_code_weight_analyzer.sv =====
// ============================================================================
// ring_code_weight_analyzer
// Weight enumerator for a code over the four-symbol ring {0,a,b,c}.
// ============================================================================
// Usage: generator rows are written through wr_en/wr_index/wr_data while the
// block is idle; an index past the last row is dropped. Items arrive on the
// item channel and each gives exactly one word on the result channel, in order.
// A mode 0 word encodes a message, updates the weight histogram and the running
// minimum weight; a mode 1 word tests a candidate for duality and counts it.
// A set clear bit wipes histogram, minimum and dual count before the item.
// An accepted item is registered in the RAM stage and then in the output register.
// Throughput: one item per cycle while the receiver does not stall. The
// histogram lives in a one-read one-write RAM; the read is issued at
// acceptance and the read-modify-write completes when the item leaves the RAM
// stage, with the last written entry forwarded to cover back-to-back hits on the same bin.
// Reset clears the rows, the statistics and all handshake state at once; per
// bin valid bits stand in for clearing the RAM, so no clearing pass is needed.
// When the receiver stalls, the output register holds its word and the item in
// the RAM stage waits; one more item is still taken while the stage is empty.
// ============================================================================
`default_nettype none

module ring_code_weight_analyzer import rcwa_pkg::*; #(
	parameter int SYMBOLS = 6,
	parameter int ROWS    = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [REG_W-1:0]     wr_data,
	rcwa_item_if.sink                 item,
	rcwa_result_if.source             result
);

	`include "assert_macros.svh"

	// Histogram has one bin per weight from zero up to SYMBOLS.
	localparam int DEPTH = SYMBOLS + 1;
	localparam int HAW   = $clog2(DEPTH);
	localparam int LW_W  = $clog2(SYMBOLS + 1);
	localparam int ZC_W  = $clog2(SYMBOLS + 1) + 1;

	// Generator rows; the user must write them only while idle, the block does not enforce it.
	gen_rows_t gen_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_rows_q <= '0;
		end else if (wr_en && (wr_index < CFG_IDX_W'(REG_COUNT))) begin
			gen_rows_q[wr_index[REG_IDX_W-1:0]] <= wr_data;
		end
	end

	// Front end: codeword, counts and duality straight from the input word.
	sym_res_t res;

	rcwa_symbol_unit #(
		.SYMBOLS (SYMBOLS),
		.ROWS    (ROWS)
	) u_sym (
		.mode      (item.mode),
		.message   (item.message),
		.candidate (item.candidate),
		.gen_rows  (gen_rows_q),
		.res       (res)
	);

	logic accept;
	logic adv;
	logic s1_vld_q;
	logic out_vld_q;

	assign adv        = !out_vld_q || result.ready;
	assign item.ready = !s1_vld_q || adv;
	assign accept     = item.valid && item.ready;

	// Stage 1 registers: the item waits here while the RAM read completes.
	sym_res_t       res_s1;
	logic           mode_s1;
	logic           clear_s1;
	logic           msg_nz_s1;
	logic [HAW-1:0] addr_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1    <= res;
			mode_s1   <= item.mode;
			clear_s1  <= item.clear;
			msg_nz_s1 <= |item.message[ROWS-1:0];
			addr_s1   <= HAW'(res.weight);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (accept) begin
			s1_vld_q <= 1'b1;
		end else if (adv) begin
			s1_vld_q <= 1'b0;
		end
	end

	// Histogram RAM.
	logic             hist_we;
	logic [BIN_W-1:0] hist_rdata;
	logic [BIN_W-1:0] bin_new;
	logic             s1_go;

	assign s1_go   = s1_vld_q && adv;
	assign hist_we = s1_go && (mode_s1 == MODE_ENCODE);

	rcwa_hist_ram #(
		.DEPTH (DEPTH),
		.AW    (HAW),
		.DW    (BIN_W)
	) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (addr_s1),
		.wdata (bin_new),
		.re    (accept),
		.raddr (HAW'(res.weight)),
		.rdata (hist_rdata)
	);

	// A bin that is not marked valid reads as zero, so a clear needs no pass over the RAM.
	logic [DEPTH-1:0] bin_vld_q;
	logic [DEPTH-1:0] bin_sel;

	// The last write is kept so that the next item sees it even though its
	// read was issued in the same cycle as that write.
	logic             fwd_vld_q;
	logic [HAW-1:0]   fwd_addr_q;
	logic [BIN_W-1:0] fwd_data_q;

	logic [BIN_W-1:0]  bin_old;
	logic [LW_W-1:0]   lw_q;
	logic [LW_W-1:0]   lw_cur;
	logic [LW_W-1:0]   lw_next;
	logic [LW_W-1:0]   w_lw;
	logic [DUAL_W-1:0] dt_q;
	logic [DUAL_W-1:0] dt_cur;
	logic [DUAL_W-1:0] dt_next;
	logic [ZC_W-1:0]   zero_cnt;

	always_comb begin
		bin_sel = '0;
		bin_sel[addr_s1] = 1'b1;
		if (clear_s1 || !bin_vld_q[addr_s1]) begin
			bin_old = '0;
		end else if (fwd_vld_q && (fwd_addr_q == addr_s1)) begin
			bin_old = fwd_data_q;
		end else begin
			bin_old = hist_rdata;
		end
		bin_new = (bin_old == BIN_MAX) ? bin_old : bin_old + 1'b1;

		lw_cur = clear_s1 ? LW_W'(SYMBOLS) : lw_q;
		w_lw   = LW_W'(res_s1.weight);
		if ((mode_s1 == MODE_ENCODE) && msg_nz_s1 && (w_lw < lw_cur)) begin
			lw_next = w_lw;
		end else begin
			lw_next = lw_cur;
		end

		dt_cur = clear_s1 ? '0 : dt_q;
		if ((mode_s1 == MODE_DUAL) && res_s1.dual && (dt_cur != DUAL_MAX)) begin
			dt_next = dt_cur + 1'b1;
		end else begin
			dt_next = dt_cur;
		end

		zero_cnt = ZC_W'(SYMBOLS) - ZC_W'(res_s1.weight);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
			fwd_vld_q <= 1'b0;
			lw_q      <= LW_W'(SYMBOLS);
			dt_q      <= '0;
		end else if (s1_go) begin
			lw_q <= lw_next;
			dt_q <= dt_next;
			if (mode_s1 == MODE_ENCODE) begin
				bin_vld_q <= (clear_s1 ? '0 : bin_vld_q) | bin_sel;
				fwd_vld_q <= 1'b1;
			end else if (clear_s1) begin
				bin_vld_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= bin_new;
		end
	end

	// Output register.
	out_word_t out_q;

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_q.codeword   <= res_s1.codeword;
			out_q.weight     <= res_s1.weight;
			out_q.zero_count <= (mode_s1 == MODE_ENCODE) ? CNT_W'(zero_cnt) : '0;
			out_q.a_count    <= res_s1.a_cnt;
			out_q.b_count    <= res_s1.b_cnt;
			out_q.c_count    <= res_s1.c_cnt;
			out_q.bin_count  <= (mode_s1 == MODE_ENCODE) ? bin_new : '0;
			out_q.min_weight <= CNT_W'(lw_next);
			out_q.is_dual    <= res_s1.dual;
			out_q.dual_count <= dt_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= s1_vld_q;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.codeword   = out_q.codeword;
	assign result.weight     = out_q.weight;
	assign result.zero_count = out_q.zero_count;
	assign result.a_count    = out_q.a_count;
	assign result.b_count    = out_q.b_count;
	assign result.c_count    = out_q.c_count;
	assign result.bin_count  = out_q.bin_count;
	assign result.min_weight = out_q.min_weight;
	assign result.is_dual    = out_q.is_dual;
	assign result.dual_count = out_q.dual_count;

	// The running minimum only falls unless a clear comes through.
	`ASSERT_NEXT(a_min_monotonic, clk, arst_n, s1_go && !clear_s1, lw_q <= $past(lw_q), "minimum weight rose without a clear")
	// The dual count only grows unless a clear comes through.
	`ASSERT_NEXT(a_dual_monotonic, clk, arst_n, s1_go && !clear_s1, dt_q >= $past(dt_q), "dual count fell without a clear")
	// The reported weight is the sum of the nonzero symbol counts.
	`ASSERT_SAME(a_weight_sum, clk, arst_n, result.valid, {2'b00, result.weight} == ({2'b00, result.a_count} + {2'b00, result.b_count} + {2'b00, result.c_count}), "weight differs from symbol counts")
	// A mode 0 word always lands in a nonzero histogram bin.
	`ASSERT_SAME(a_bin_nonzero, clk, arst_n, hist_we, bin_new != '0, "histogram bin written as zero")

endmodule

`default_nettype wire
